FILE: rtl/bfac_pkg.sv
// Package for the Bloom filter add/check block: hash constants, command and status types.
// Used by bfac_ctrl, bfac_datapath and bloom_filter_add_check_core; depends on nothing.
`default_nettype none
package bfac_pkg;
    localparam logic [31:0] FNV_BASIS = 32'h811c9dc5;
    localparam logic [31:0] FNV_PRIME = 32'h01000193;
    localparam logic [31:0] MUR_C1    = 32'hcc9e2d51;
    localparam logic [31:0] MUR_C2    = 32'h1b873593;
    localparam logic [31:0] MUR_N     = 32'he6546b64;
    localparam logic [31:0] MUR_F1    = 32'h85ebca6b;
    localparam logic [31:0] MUR_F2    = 32'hc2b2ae35;
    localparam logic        KIND_ADD  = 1'b0;
    localparam logic        KIND_CHK  = 1'b1;

    typedef struct packed {
        logic clr_step;
        logic load;
        logic hash_step;
        logic probe_start;
        logic div_step;
        logic mem_access;
        logic probe_next;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic hash_done;
        logic div_done;
        logic probes_done;
        logic bit_val;
        logic is_check;
    } t_stat;
endpackage
`default_nettype wire

FILE: rtl/bfac_datapath.sv
// Datapath: hash sequencer, restoring divider for the bit position, filter bit memory.
// Depends on bfac_pkg; driven by bfac_ctrl through t_cmd.
`default_nettype none
module bfac_datapath #(
    parameter int FILTER_BITS = 1024,
    parameter int PROBE_COUNT = 4,
    parameter int KEY_BYTES   = 4
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire bfac_pkg::t_cmd i_cmd,
    output bfac_pkg::t_stat     o_stat,
    input  wire logic           i_kind,
    input  wire logic [31:0]    i_key,
    input  wire logic [10:0]    i_size
);
    localparam int AW = (FILTER_BITS > 1) ? $clog2(FILTER_BITS) : 1;
    localparam int SW = $clog2(FILTER_BITS + 1);
    localparam int PW = $clog2(PROBE_COUNT + 1);
    localparam int HSTEPS = KEY_BYTES + 7;
    localparam int HW = $clog2(HSTEPS + 1);

    logic              r_clr_done;
    logic [AW-1:0]     r_clr_addr;
    logic              r_kind;
    logic [31:0]       r_key;
    logic [31:0]       r_h1;
    logic [31:0]       n_h1;
    logic [31:0]       r_h2;
    logic [31:0]       n_h2;
    logic [31:0]       r_tmp;
    logic [31:0]       n_tmp;
    logic [HW-1:0]     r_hcnt;
    logic [31:0]       r_pos;
    logic [PW-1:0]     r_pcnt;
    logic [31:0]       r_quo;
    logic [SW-1:0]     r_rem;
    logic [5:0]        r_dcnt;
    logic [SW-1:0]     r_size;
    logic              r_bit;
    logic [FILTER_BITS-1:0] r_mem;
    logic [SW-1:0]     size_eff;
    logic [SW:0]       rem_sh;
    logic [31:0]       mblk;
    logic [7:0]        kbyte;

    always_comb begin
        if (i_size == 11'd0) begin
            size_eff = SW'(1);
        end else if (32'(i_size) > 32'(FILTER_BITS)) begin
            size_eff = SW'(FILTER_BITS);
        end else begin
            size_eff = SW'(i_size);
        end
    end

    always_comb begin
        mblk = '0;
        for (int b = 0; b < 4; b++) begin
            if (b < KEY_BYTES) begin
                mblk[8*b +: 8] = r_key[8*b +: 8];
            end
        end
        kbyte = (32'(r_hcnt) < 32'd4) ? r_key[8*r_hcnt[1:0] +: 8] : 8'd0;
    end

    // one multiply per hash per register step (h1 takes two in step 2 when KEY_BYTES >= 8)
    always_comb begin
        n_h1  = r_h1;
        n_tmp = r_tmp;
        n_h2  = r_h2;
        if (32'(r_hcnt) < 32'(KEY_BYTES)) begin
            n_h2 = (r_h2 ^ {24'd0, kbyte}) * bfac_pkg::FNV_PRIME;
        end
        case (r_hcnt)
            HW'(0): n_tmp = mblk * bfac_pkg::MUR_C1;
            HW'(1): n_tmp = {r_tmp[16:0], r_tmp[31:17]} * bfac_pkg::MUR_C2;
            HW'(2): begin
                if (KEY_BYTES >= 4) begin
                    n_h1 = ({r_tmp[18:0], r_tmp[31:19]} * 32'd5) + bfac_pkg::MUR_N;
                    if (KEY_BYTES >= 8) begin
                        n_h1 = ({n_h1[18:0], n_h1[31:19]} * 32'd5) + bfac_pkg::MUR_N;
                    end
                end else begin
                    n_h1 = r_tmp;
                end
                n_h1 = n_h1 ^ 32'(KEY_BYTES);
                n_h1 = n_h1 ^ (n_h1 >> 16);
            end
            HW'(3): n_h1 = r_h1 * bfac_pkg::MUR_F1;
            HW'(4): begin
                n_h1 = r_h1 ^ (r_h1 >> 13);
            end
            HW'(5): n_h1 = r_h1 * bfac_pkg::MUR_F2;
            HW'(6): n_h1 = r_h1 ^ (r_h1 >> 16);
            default: ;
        endcase
    end

    assign rem_sh = {r_rem, r_quo[31]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_done <= 1'b0;
            r_clr_addr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (32'(r_clr_addr) == 32'(FILTER_BITS - 1)) begin
                r_clr_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            r_mem[r_clr_addr] <= 1'b0;
        end else if (i_cmd.mem_access) begin
            if (r_kind == bfac_pkg::KIND_ADD) begin
                r_mem[AW'(r_rem)] <= 1'b1;
            end
            r_bit <= r_mem[AW'(r_rem)];
        end
    end

    // probe i position runs as pos = h1 + i*h2, divided by restoring steps
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_key  <= i_key;
            r_h1   <= '0;
            r_h2   <= bfac_pkg::FNV_BASIS;
            r_tmp  <= '0;
            r_hcnt <= '0;
            r_size <= size_eff;
        end else if (i_cmd.hash_step) begin
            r_h1   <= n_h1;
            r_h2   <= n_h2;
            r_tmp  <= n_tmp;
            r_hcnt <= r_hcnt + HW'(1);
        end
        if (i_cmd.probe_start) begin
            r_pos  <= r_h1;
            r_quo  <= r_h1;
            r_rem  <= '0;
            r_dcnt <= '0;
            r_pcnt <= '0;
        end else if (i_cmd.div_step) begin
            r_quo  <= {r_quo[30:0], 1'b0};
            r_rem  <= (rem_sh >= {1'b0, r_size}) ? SW'(rem_sh - {1'b0, r_size})
                                                 : SW'(rem_sh);
            r_dcnt <= r_dcnt + 6'd1;
        end else if (i_cmd.probe_next) begin
            r_pos  <= r_pos + r_h2;
            r_quo  <= r_pos + r_h2;
            r_rem  <= '0;
            r_dcnt <= '0;
            r_pcnt <= r_pcnt + PW'(1);
        end
    end

    assign o_stat.clr_done    = r_clr_done;
    assign o_stat.hash_done   = (32'(r_hcnt) >= 32'(HSTEPS));
    assign o_stat.div_done    = (r_dcnt == 6'd32);
    assign o_stat.probes_done = (32'(r_pcnt) == 32'(PROBE_COUNT - 1));
    assign o_stat.bit_val     = r_bit;
    assign o_stat.is_check    = r_kind;
endmodule
`default_nettype wire

FILE: rtl/bfac_ctrl.sv
// Controller state machine: clearing pass, hashing, per-probe divide and memory access.
// Depends on bfac_pkg; commands bfac_datapath.
`default_nettype none
module bfac_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    output logic                 o_present,
    output bfac_pkg::t_cmd       o_cmd,
    input  wire bfac_pkg::t_stat i_stat
);
    localparam logic [2:0] ST_CLR  = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_HASH = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_MEM  = 3'd4;
    localparam logic [2:0] ST_CHK  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_ok;
    logic       n_ok;
    logic       r_out_valid;
    logic       r_present;
    logic       fin;
    logic       fin_val;

    assign o_in_stall = (r_state != ST_IDLE) || r_out_valid;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_ok    = r_ok;
        fin     = 1'b0;
        fin_val = 1'b0;
        case (r_state)
            ST_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_done) begin
                    o_cmd.clr_step = 1'b0;
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid && !r_out_valid) begin
                    o_cmd.load = 1'b1;
                    n_ok    = 1'b1;
                    n_state = ST_HASH;
                end
            end
            ST_HASH: begin
                if (i_stat.hash_done) begin
                    o_cmd.probe_start = 1'b1;
                    n_state = ST_DIV;
                end else begin
                    o_cmd.hash_step = 1'b1;
                end
            end
            ST_DIV: begin
                if (i_stat.div_done) begin
                    o_cmd.mem_access = 1'b1;
                    n_state = ST_MEM;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            ST_MEM: n_state = ST_CHK;
            ST_CHK: begin
                n_ok = r_ok & i_stat.bit_val;
                if (i_stat.probes_done) begin
                    fin     = i_stat.is_check;
                    fin_val = n_ok;
                    n_state = ST_IDLE;
                end else begin
                    o_cmd.probe_next = 1'b1;
                    n_state = ST_DIV;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLR;
            r_ok        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ok    <= n_ok;
            if (fin) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin) begin
            r_present <= fin_val;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_present   = r_present;

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> o_in_stall)
        else $error("accept outside idle");
    a_fin_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin |-> !r_out_valid)
        else $error("result overwritten");
    a_out_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin |=> o_out_valid)
        else $error("result lost");
endmodule
`default_nettype wire

FILE: rtl/bloom_filter_add_check_core.sv
// Top level of the Bloom filter add/check block; joins bfac_ctrl and bfac_datapath.
// Depends on bfac_pkg.
//
// channel  | handshake                | payload
// input    | i_in_valid / o_in_stall  | i_kind, i_key
// output   | o_out_valid / i_out_stall| o_present
// config   | i_cfg_valid / o_cfg_ready| i_cfg_size_in_use
//
// An accepted item runs through the hash steps and then, for each of the PROBE_COUNT
// probes, through the 32-step restoring divider for its bit position and a memory access.
// After reset a clearing pass over all FILTER_BITS bits runs, then the block enters idle;
// no item is taken during the clearing pass.
// A new item is taken only in idle and once the previous result has left the output
// register. Only a check gives a result; an add gives none.
`default_nettype none
module bloom_filter_add_check_core #(
    parameter int FILTER_BITS = 1024,
    parameter int PROBE_COUNT = 4,
    parameter int KEY_BYTES   = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_kind,
    input  wire logic [31:0] i_key,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_present,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [10:0] i_cfg_size_in_use
);
    bfac_pkg::t_cmd  cmd;
    bfac_pkg::t_stat stat;
    logic [10:0]     r_size;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= 11'd1024;
        end else if (i_cfg_valid) begin
            r_size <= i_cfg_size_in_use;
        end
    end

    bfac_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_present   (o_present),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    bfac_datapath #(
        .FILTER_BITS (FILTER_BITS),
        .PROBE_COUNT (PROBE_COUNT),
        .KEY_BYTES   (KEY_BYTES)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .i_kind  (i_kind),
        .i_key   (i_key),
        .i_size  (r_size)
    );
endmodule
`default_nettype wire

FILE: test/bloom_filter_add_check_core_test.sv
// Testbench for bloom_filter_add_check_core: adds and checks keys with random idling
// and checks each present flag against a predictor kept inside this file.
// Depends on bfac_pkg and the RTL of the block.
`default_nettype none
module bloom_filter_add_check_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FILTER_BITS = 1024;
    localparam int PROBE_COUNT = 4;
    localparam int KEY_BYTES   = 4;
    localparam int SETTLE      = 200;
    localparam int LIMIT       = 2000000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_kind;
    logic [31:0] i_key;
    logic        o_out_valid;
    logic        i_out_stall;
    logic        o_present;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [10:0] i_cfg_size_in_use;

    bloom_filter_add_check_core #(
        .FILTER_BITS(FILTER_BITS),
        .PROBE_COUNT(PROBE_COUNT),
        .KEY_BYTES(KEY_BYTES)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_kind(i_kind),
        .i_key(i_key),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_present(o_present),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_size_in_use(i_cfg_size_in_use)
    );

    logic        filter_model [FILTER_BITS];
    logic [10:0] size_model;
    logic        present_queue [$];
    logic [31:0] added_keys [$];
    int          mismatches;
    int          cycles;
    bit          quiet;
    int          stall_left;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [31:0] rotl(logic [31:0] x, int r);
        return (x << r) | (x >> (32 - r));
    endfunction

    function automatic logic [31:0] murmur_key(logic [31:0] key);
        logic [31:0] k;
        logic [31:0] h;
        k = key * bfac_pkg::MUR_C1;
        k = rotl(k, 15);
        k = k * bfac_pkg::MUR_C2;
        h = rotl(k, 13);
        h = h * 32'd5 + bfac_pkg::MUR_N;
        h = h ^ 32'(KEY_BYTES);
        h = h ^ (h >> 16);
        h = h * bfac_pkg::MUR_F1;
        h = h ^ (h >> 13);
        h = h * bfac_pkg::MUR_F2;
        h = h ^ (h >> 16);
        return h;
    endfunction

    function automatic logic [31:0] fnv_key(logic [31:0] key);
        logic [31:0] h;
        h = bfac_pkg::FNV_BASIS;
        for (int b = 0; b < KEY_BYTES; b++) begin
            h = (h ^ ((b < 4) ? {24'd0, key[8*b +: 8]} : 32'd0)) * bfac_pkg::FNV_PRIME;
        end
        return h;
    endfunction

    // update the filter for one transaction; return 1 when a flag is due
    function automatic bit predict_filter(logic kind, logic [31:0] key, output logic hit);
        logic [31:0] h1;
        logic [31:0] h2;
        logic [31:0] span;
        logic [31:0] pos;
        h1 = murmur_key(key);
        h2 = fnv_key(key);
        span = (size_model == 11'd0) ? 32'd1 :
               (32'(size_model) > 32'(FILTER_BITS)) ? 32'(FILTER_BITS) : {21'd0, size_model};
        hit = 1'b1;
        for (int i = 0; i < PROBE_COUNT; i++) begin
            pos = (h1 + 32'(i) * h2) % span;
            if (kind == bfac_pkg::KIND_ADD) begin
                filter_model[pos] = 1'b1;
            end else if (!filter_model[pos]) begin
                hit = 1'b0;
            end
        end
        return kind == bfac_pkg::KIND_CHK;
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch at cycle %0d: %s", cycles, what);
        mismatches++;
    endtask

    task automatic send_item(logic kind, logic [31:0] key);
        int gap;
        logic hit;
        gap = (!quiet && $urandom_range(0, 5) == 0) ? $urandom_range(1, 18) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind <= kind;
        i_key <= key;
        do @(posedge i_clk); while (o_in_stall);
        if (predict_filter(kind, key, hit)) begin
            present_queue.push_back(hit);
        end
        if (kind == bfac_pkg::KIND_ADD) begin
            added_keys.push_back(key);
        end
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (present_queue.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_size(logic [10:0] value);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_size_in_use <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        size_model = value;
    endtask

    task automatic test_directed_keys();
        send_item(bfac_pkg::KIND_CHK, 32'h0000_0000);
        send_item(bfac_pkg::KIND_ADD, 32'h0000_0000);
        send_item(bfac_pkg::KIND_CHK, 32'h0000_0000);
        send_item(bfac_pkg::KIND_CHK, 32'hffff_ffff);
        send_item(bfac_pkg::KIND_ADD, 32'hffff_ffff);
        send_item(bfac_pkg::KIND_CHK, 32'hffff_ffff);
        send_item(bfac_pkg::KIND_CHK, 32'h5555_aaaa);
        send_item(bfac_pkg::KIND_ADD, 32'ha5a5_5a5a);
        send_item(bfac_pkg::KIND_CHK, 32'ha5a5_5a5a);
        send_item(bfac_pkg::KIND_CHK, 32'h0000_0001);
        send_item(bfac_pkg::KIND_CHK, 32'h8000_0000);
    endtask

    task automatic test_size_extremes();
        write_size(11'd0);
        send_item(bfac_pkg::KIND_CHK, 32'h1234_5678);
        send_item(bfac_pkg::KIND_ADD, 32'h1234_5678);
        send_item(bfac_pkg::KIND_CHK, 32'hdead_beef);
        write_size(11'd1);
        send_item(bfac_pkg::KIND_CHK, 32'h0bad_f00d);
        write_size(11'd2047);
        send_item(bfac_pkg::KIND_CHK, 32'hcafe_0001);
        send_item(bfac_pkg::KIND_ADD, 32'hcafe_0001);
        send_item(bfac_pkg::KIND_CHK, 32'hcafe_0001);
        write_size(11'd1025);
        send_item(bfac_pkg::KIND_CHK, 32'h0000_ffff);
        write_size(11'd1024);
    endtask

    task automatic test_random_traffic(int count, logic [10:0] size);
        logic [31:0] key;
        write_size(size);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 2) == 0) begin
                send_item(bfac_pkg::KIND_ADD, $urandom());
            end else begin
                key = (added_keys.size() > 0 && $urandom_range(0, 1) == 0) ?
                      added_keys[$urandom_range(0, added_keys.size() - 1)] : $urandom();
                send_item(bfac_pkg::KIND_CHK, key);
            end
        end
        drain_results();
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n || quiet) begin
            i_out_stall <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 7) == 0) begin
            i_out_stall <= 1'b1;
            stall_left <= $urandom_range(1, 18);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (present_queue.size() == 0) begin
                report_mismatch("present flag with no transaction waiting");
            end else begin
                if (o_present !== present_queue[0]) begin
                    report_mismatch($sformatf("present %b, predicted %b",
                                              o_present, present_queue[0]));
                end
                present_queue.pop_front();
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        cycles = 0;
        mismatches = 0;
        quiet = 1'b0;
        stall_left = 0;
        size_model = 11'd1024;
        for (int i = 0; i < FILTER_BITS; i++) begin
            filter_model[i] = 1'b0;
        end
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_kind <= bfac_pkg::KIND_ADD;
        i_key <= 32'd0;
        i_out_stall <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_size_in_use <= 11'd0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_keys();
        test_size_extremes();
        test_random_traffic(500, 11'd1024);
        test_random_traffic(300, 11'($urandom_range(64, 1023)));
        test_random_traffic(250, 11'($urandom_range(8, 63)));
        test_random_traffic(150, 11'd2047);
        test_random_traffic(100, 11'd1);
        test_random_traffic(150, 11'd0);
        test_random_traffic(200, 11'($urandom_range(200, 1023)));
        quiet = 1'b1;
        test_random_traffic(250, 11'd1024);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
